// ===== src/msqe_pkg.sv =====
// Package for the multiple stack and queue engine: command codes, status codes and beat types.
package msqe_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         list_id;
    logic               kind;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] pop_value;
    logic               pop_valid;
  } result_t;

endpackage

// ===== src/multi_stack_queue_engine_top.sv =====
// Top level of the multiple stack and queue engine: slot table, entry memory and result stage.
// Result path: an accepted command is registered in cmd_q and cmd_vld, then its beat in done and the result register.
// Throughput: one command per cycle; busy stays low, as the slot table is updated in the
// cycle after acceptance and the single memory port serves one access per command.
// Reset: synchronous rst clears every slot (none exist) and drops any beat in flight.
// The entry memory is not cleared; a pop only reads entries written by an earlier push.
// The receiver cannot stall: done marks each result beat for exactly one cycle.
module multi_stack_queue_engine_top
  import msqe_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int SLOT_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W  = $clog2(SLOT_DEPTH);
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int MEM_DEPTH = NUM_SLOTS * SLOT_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Input register.
  cmd_t cmd_q;
  logic cmd_vld;

  // Slot table.
  logic             exists   [NUM_SLOTS];
  logic             is_queue [NUM_SLOTS];
  logic [PTR_W-1:0] front    [NUM_SLOTS];
  logic [CNT_W-1:0] count    [NUM_SLOTS];

  // Entry memory.
  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  // Result register.
  status_e status_q;
  logic    popped_q;

  // Decode of the registered command.
  logic [SLOT_W-1:0] slot;
  logic              in_range;
  logic              present;
  logic              cur_queue;
  logic [PTR_W-1:0]  cur_front;
  logic [CNT_W-1:0]  cur_count;
  logic [SUM_W-1:0]  back_sum;
  logic [PTR_W-1:0]  back_pos;
  logic [PTR_W-1:0]  prev_pos;
  logic [PTR_W-1:0]  next_pos;
  logic [PTR_W-1:0]  pos;
  logic [ADDR_W-1:0] addr;
  logic [31:0]       push_raw;
  logic [DATA_WIDTH-1:0] wr_word;

  logic             do_create;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] front_next;
  logic [CNT_W-1:0] count_next;
  logic             upd_slot;
  status_e          status_next;

  assign busy = 1'b0;

  assign slot      = SLOT_W'(cmd_q.list_id);
  assign in_range  = ({29'd0, cmd_q.list_id} < NUM_SLOTS);
  assign present   = in_range && exists[slot];
  assign cur_queue = is_queue[slot];
  assign cur_front = front[slot];
  assign cur_count = count[slot];

  // Ring arithmetic: front plus count stays below twice the depth, so one subtract suffices.
  assign back_sum = SUM_W'(cur_front) + SUM_W'(cur_count);
  assign back_pos = (back_sum >= SUM_W'(SLOT_DEPTH)) ?
                    PTR_W'(back_sum - SUM_W'(SLOT_DEPTH)) : PTR_W'(back_sum);
  assign prev_pos = (cur_front == '0) ? PTR_W'(SLOT_DEPTH - 1) : cur_front - 1'b1;
  assign next_pos = (cur_front == PTR_W'(SLOT_DEPTH - 1)) ? '0 : cur_front + 1'b1;

  assign addr     = ADDR_W'(slot * SLOT_DEPTH) + ADDR_W'(pos);
  assign push_raw = cmd_q.push_value;
  assign wr_word  = DATA_WIDTH'(push_raw);

  always_comb begin
    status_next = ST_OK;
    do_create   = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    upd_slot    = 1'b0;
    pos         = cur_front;
    front_next  = cur_front;
    count_next  = cur_count;
    case (cmd_q.operation)
      OP_CREATE: begin
        if (!in_range) begin
          status_next = ST_MISSING;
        end else if (present) begin
          status_next = ST_EXISTS;
        end else begin
          do_create = 1'b1;
        end
      end
      OP_PUSH: begin
        if (!present) begin
          status_next = ST_MISSING;
        end else if (cur_count == CNT_W'(SLOT_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          upd_slot   = 1'b1;
          count_next = cur_count + 1'b1;
          if (cur_queue) begin
            pos = back_pos;
          end else begin
            pos        = prev_pos;
            front_next = prev_pos;
          end
        end
      end
      OP_POP: begin
        if (!present) begin
          status_next = ST_MISSING;
        end else if (cur_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          upd_slot   = 1'b1;
          front_next = next_pos;
          count_next = cur_count - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else begin
      cmd_vld <= start && !busy;
    end
    cmd_q <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        exists[i]   <= 1'b0;
        is_queue[i] <= 1'b0;
        front[i]    <= '0;
        count[i]    <= '0;
      end
    end else if (cmd_vld) begin
      if (do_create) begin
        exists[slot]   <= 1'b1;
        is_queue[slot] <= cmd_q.kind;
        front[slot]    <= '0;
        count[slot]    <= '0;
      end else if (upd_slot) begin
        front[slot] <= front_next;
        count[slot] <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld && wr_en) begin
      mem[addr] <= wr_word;
    end
    if (cmd_vld && rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      popped_q <= 1'b0;
    end else begin
      done     <= cmd_vld;
      popped_q <= cmd_vld && rd_en;
    end
    status_q <= status_next;
  end

  assign result.status    = status_q;
  assign result.pop_value = popped_q ? 32'(rd_data) : '0;
  assign result.pop_valid = popped_q;

  // A popped word only ever comes with a good status.
  assert property (@(posedge clk) disable iff (rst)
    done && result.pop_valid |-> result.status == ST_OK)
    else $error("pop_valid set on a failed command");

  // Each accepted command gives exactly one result beat, registered through cmd_vld and then done.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result beat missing after an accepted command");

  // A slot never holds more words than its depth.
  assert property (@(posedge clk) disable iff (rst)
    cmd_vld |-> cur_count <= CNT_W'(SLOT_DEPTH))
    else $error("slot count exceeds its depth");

  // A beat without a popped word carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    done && !result.pop_valid |-> result.pop_value == '0)
    else $error("pop_value not zero without a popped word");

endmodule

// ===== bench/msqe_checker.sv =====
// Checker for the stack and queue engine: predicts each result beat and compares it.
`timescale 1ns / 100ps

module msqe_checker
  import msqe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      fail_count,
  output int      outstanding,
  output int      cmd_count,
  output int      result_count,
  output int      popped_words,
  output int      full_hits,
  output int      empty_hits,
  output int      exists_hits,
  output int      missing_hits
);

  localparam int SLOTS = 8;
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  logic                slot_live  [SLOTS];
  logic                slot_fifo  [SLOTS];
  logic [PTR_W-1:0]    slot_front [SLOTS];
  logic [PTR_W:0]      slot_fill  [SLOTS];
  logic signed [31:0]  words      [SLOTS*DEPTH];

  result_t expected_results [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    cmd_count    = 0;
    result_count = 0;
    popped_words = 0;
    full_hits    = 0;
    empty_hits   = 0;
    exists_hits  = 0;
    missing_hits = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_fifo[i]  = 1'b0;
      slot_front[i] = '0;
      slot_fill[i]  = '0;
    end
  end

  // Applies one command to the shadow slot table and returns the beat it should give.
  function automatic result_t apply_command(cmd_t c);
    result_t          r;
    int               s;
    logic [PTR_W-1:0] pos;
    r.status    = ST_OK;
    r.pop_value = '0;
    r.pop_valid = 1'b0;
    s = int'(c.list_id);
    case (c.operation)
      OP_CREATE: begin
        if (slot_live[s]) begin
          r.status = ST_EXISTS;
        end else begin
          slot_live[s]  = 1'b1;
          slot_fifo[s]  = c.kind;
          slot_front[s] = '0;
          slot_fill[s]  = '0;
        end
      end
      OP_PUSH: begin
        if (!slot_live[s]) begin
          r.status = ST_MISSING;
        end else if (slot_fill[s] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // A queue appends behind the last word; a stack steps the front back.
          if (slot_fifo[s]) begin
            pos = slot_front[s] + slot_fill[s][PTR_W-1:0];
          end else begin
            pos = slot_front[s] - 1'b1;
            slot_front[s] = pos;
          end
          words[s*DEPTH + pos] = c.push_value;
          slot_fill[s] = slot_fill[s] + 1'b1;
        end
      end
      OP_POP: begin
        if (!slot_live[s]) begin
          r.status = ST_MISSING;
        end else if (slot_fill[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value   = words[s*DEPTH + slot_front[s]];
          r.pop_valid   = 1'b1;
          slot_front[s] = slot_front[s] + 1'b1;
          slot_fill[s]  = slot_fill[s] - 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual %0h",
                   $time, result);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status) begin
            report_field("status", 32'(want.status), 32'(result.status));
          end
          if (result.pop_value !== want.pop_value) begin
            report_field("pop_value", want.pop_value, result.pop_value);
          end
          if (result.pop_valid !== want.pop_valid) begin
            report_field("pop_valid", 32'(want.pop_valid), 32'(result.pop_valid));
          end
        end
      end
      if (start && !busy) begin
        cmd_count++;
        want = apply_command(cmd);
        case (want.status)
          ST_FULL:    full_hits++;
          ST_EMPTY:   empty_hits++;
          ST_EXISTS:  exists_hits++;
          ST_MISSING: missing_hits++;
          default: begin
          end
        endcase
        if (want.pop_valid) begin
          popped_words++;
        end
        expected_results = {expected_results, want};
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== bench/multi_stack_queue_engine_top_tb.sv =====
// Testbench top for the stack and queue engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module multi_stack_queue_engine_top_tb;
  import msqe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  int fail_count, outstanding, cmd_count, result_count, popped_words;
  int full_hits, empty_hits, exists_hits, missing_hits;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  multi_stack_queue_engine_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  msqe_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .cmd_count    (cmd_count),
    .result_count (result_count),
    .popped_words (popped_words),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits),
    .exists_hits  (exists_hits),
    .missing_hits (missing_hits)
  );

  // The run is stopped if no beat moves in either direction for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, int id, logic kind, logic [31:0] value);
    cmd_t c;
    c.operation  = op;
    c.list_id    = id[2:0];
    c.kind       = kind;
    c.push_value = value;
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Most commands target one focus slot so that it can be driven to full or empty.
  function automatic cmd_t random_cmd(int push_pct, int focus);
    int         r;
    int         id;
    logic [1:0] op;
    id = ($urandom_range(99) < 60) ? focus : $urandom_range(7);
    r  = $urandom_range(99);
    if (r < 2) begin
      op = OP_UNUSED;
    end else if (r < 8) begin
      op = OP_CREATE;
    end else if (r < 8 + (push_pct * 92) / 100) begin
      op = OP_PUSH;
    end else begin
      op = OP_POP;
    end
    return make_cmd(op, id, 1'($urandom_range(1)), pick_word());
  endfunction

  // Start stays high across back-to-back beats and only drops when a gap is wanted.
  task automatic issue(cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  // A clock edge passes first so that the last accepted beat is already counted.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int push_pct;
    int focus;
    bool_gaps_block : begin
    end
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: missing slot, double create, empty pop, fill past full, both kinds.
    issue(make_cmd(OP_POP, 3, 1'b0, 32'h0), 0);
    issue(make_cmd(OP_PUSH, 3, 1'b0, 32'h1234_5678), 0);
    issue(make_cmd(OP_CREATE, 3, 1'b0, 32'h0), 0);
    issue(make_cmd(OP_CREATE, 3, 1'b1, 32'h0), 1);
    issue(make_cmd(OP_POP, 3, 1'b0, 32'h0), 0);
    issue(make_cmd(OP_PUSH, 3, 1'b0, 32'h8000_0000), 0);
    issue(make_cmd(OP_PUSH, 3, 1'b0, 32'h7FFF_FFFF), 0);
    issue(make_cmd(OP_PUSH, 3, 1'b0, 32'h0000_0000), 2);
    issue(make_cmd(OP_PUSH, 3, 1'b0, 32'hFFFF_FFFF), 0);
    for (int i = 4; i < 17; i++) begin
      issue(make_cmd(OP_PUSH, 3, 1'b0, $urandom), 0);
    end
    issue(make_cmd(OP_POP, 3, 1'b0, 32'h0), 0);
    issue(make_cmd(OP_CREATE, 7, 1'b1, 32'h0), 0);
    issue(make_cmd(OP_PUSH, 7, 1'b0, 32'hA5A5_5A5A), 0);
    issue(make_cmd(OP_PUSH, 7, 1'b1, 32'h5A5A_A5A5), 0);
    issue(make_cmd(OP_POP, 7, 1'b0, 32'h0), 0);
    issue(make_cmd(OP_UNUSED, 7, 1'b1, 32'hFFFF_FFFF), 0);
    wait_idle();

    // Random part: phases alternate between filling and draining, some without gaps.
    for (int p = 0; p < PHASES; p++) begin
      push_pct = (p % 2 == 0) ? $urandom_range(95, 60) : $urandom_range(40, 5);
      focus    = $urandom_range(7);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_cmd(push_pct, focus), (p % 3 == 2) ? 0 : pick_gap());
      end
      if (p % 4 == 1) begin
        wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands and checked %0d result beats, %0d of them popped words.",
             cmd_count, result_count, popped_words);
    $display("Status hits: %0d full, %0d empty, %0d already existing, %0d missing slot.",
             full_hits, empty_hits, exists_hits, missing_hits);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/msqe_pkg.sv
src/multi_stack_queue_engine_top.sv
bench/msqe_checker.sv
bench/multi_stack_queue_engine_top_tb.sv
